// File: hdl/ptts_pkg.sv
// Package for the periodic task tick scheduler: sizes, command codes and the
// control and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

  localparam int NUM_TASKS   = 8;
  localparam int COUNT_WIDTH = 16;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 3;
  localparam int PERIOD_W = 16;

  // Width of an index over the slot bank.
  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  // Width that holds both a slot field and a bank index.
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  // Width for comparing a count against a period.
  localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_REGISTER   = 3'd1,
    CMD_ACTIVATE   = 3'd2,
    CMD_DEACTIVATE = 3'd3,
    CMD_SET_PERIOD = 3'd4
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic apply_cmd;
    logic clr_idx;
    logic step;
    logic finish;
  } ptts_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic out_free;
    logic idx_last;
  } ptts_stat_t;

endpackage

`default_nettype wire

// File: hdl/ptts_if.sv
// Channel interfaces of the periodic task tick scheduler: the command
// channel and the result channel. Depends on ptts_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ptts_cmd_if;
  import ptts_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SLOT_W-1:0]   slot;
  logic [PERIOD_W-1:0] period_value;

  modport source (output valid, output cmd, output slot, output period_value, input ready);
  modport sink   (input valid, input cmd, input slot, input period_value, output ready);
endinterface

interface ptts_res_if;
  import ptts_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] fired_slot;
  logic              fired;
  logic              last;

  modport source (output valid, output fired_slot, output fired, output last, input ready);
  modport sink   (input valid, input fired_slot, input fired, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/ptts_ctrl.sv
// Controller of the periodic task tick scheduler: a one-hot state machine
// that accepts transactions and sequences the slot sweep. Depends on ptts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptts_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ptts_pkg::ptts_stat_t stat_i,
  output ptts_pkg::ptts_ctl_t      ctl_o
);
  import ptts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.in_ready = stat_i.out_free;
        if (stat_i.in_valid && stat_i.out_free) begin
          if (stat_i.is_tick) begin
            ctl_o.clr_idx = 1'b1;
            state_d       = ST_SWEEP;
          end else begin
            ctl_o.apply_cmd = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        // A slot is visited only when a held result could be moved out.
        ctl_o.step = stat_i.out_free;
        if (stat_i.out_free && stat_i.idx_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        ctl_o.finish = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.in_ready |-> state_q == ST_IDLE)
    else $error("input ready outside the idle state");

  a_sweep_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && ctl_o.step && stat_i.idx_last) |=> state_q == ST_DONE)
    else $error("sweep did not close after the last slot");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");

endmodule

`default_nettype wire

// File: hdl/ptts_dp.sv
// Datapath of the periodic task tick scheduler: slot bank, sweep index,
// held fired result and output register. Depends on ptts_pkg and ptts_if.
`timescale 1ns / 1ps
`default_nettype none

module ptts_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ptts_pkg::ptts_ctl_t ctl_i,
  output ptts_pkg::ptts_stat_t     stat_o,
  ptts_cmd_if.sink                 cmd_i,
  ptts_res_if.source               res_o
);
  import ptts_pkg::*;

  logic [PERIOD_W-1:0]    period_q [NUM_TASKS];
  logic [COUNT_WIDTH-1:0] count_q  [NUM_TASKS];
  logic [NUM_TASKS-1:0]   active_q;

  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  pend_q;
  logic              has_pend_q;

  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_fired_q;
  logic              out_last_q;

  logic [EXT_W-1:0]       slot_ext;
  logic [IDX_W-1:0]       slot_idx;
  logic                   slot_ok;
  logic [EXT_W-1:0]       pend_ext;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   fire_now;
  logic                   out_free;
  logic                   load;
  cmd_e                   cmd;

  assign cmd      = cmd_e'(cmd_i.cmd);
  assign slot_ext = EXT_W'(cmd_i.slot);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign slot_ok  = int'(cmd_i.slot) < NUM_TASKS;
  assign pend_ext = EXT_W'(pend_q);

  assign cnt_inc  = count_q[idx_q] + COUNT_WIDTH'(1);
  assign fire_now = active_q[idx_q] && (CMP_W'(cnt_inc) >= CMP_W'(period_q[idx_q]));

  assign out_free = !out_valid_q || res_o.ready;
  assign load     = ctl_i.apply_cmd || ctl_i.finish || (ctl_i.step && fire_now && has_pend_q);

  assign cmd_i.ready     = ctl_i.in_ready;
  assign stat_o.in_valid = cmd_i.valid;
  assign stat_o.is_tick  = (cmd == CMD_TICK);
  assign stat_o.out_free = out_free;
  assign stat_o.idx_last = (idx_q == IDX_W'(NUM_TASKS - 1));

  // Slot bank: command writes address the given slot, the sweep the index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        period_q[i] <= '0;
        count_q[i]  <= '0;
      end
    end else if (ctl_i.apply_cmd && slot_ok) begin
      unique case (cmd)
        CMD_REGISTER: begin
          active_q[slot_idx] <= 1'b0;
          count_q[slot_idx]  <= '0;
          period_q[slot_idx] <= cmd_i.period_value;
        end
        CMD_ACTIVATE: begin
          active_q[slot_idx] <= 1'b1;
          count_q[slot_idx]  <= '0;
        end
        CMD_DEACTIVATE: begin
          active_q[slot_idx] <= 1'b0;
        end
        CMD_SET_PERIOD: begin
          count_q[slot_idx]  <= '0;
          period_q[slot_idx] <= cmd_i.period_value;
        end
        default: begin
        end
      endcase
    end else if (ctl_i.step && active_q[idx_q]) begin
      count_q[idx_q] <= fire_now ? '0 : cnt_inc;
    end
  end

  // A fired slot is held until the next one fires or the sweep ends, so that
  // the final result of a tick can carry the last flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      has_pend_q <= 1'b0;
    end else if (ctl_i.clr_idx) begin
      idx_q      <= '0;
      has_pend_q <= 1'b0;
    end else if (ctl_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (fire_now) begin
        has_pend_q <= 1'b1;
      end
    end else if (ctl_i.finish) begin
      has_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step && fire_now) begin
      pend_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (ctl_i.apply_cmd || (ctl_i.finish && !has_pend_q)) begin
        out_slot_q  <= '0;
        out_fired_q <= 1'b0;
        out_last_q  <= 1'b1;
      end else begin
        out_slot_q  <= pend_ext[SLOT_W-1:0];
        out_fired_q <= 1'b1;
        out_last_q  <= ctl_i.finish;
      end
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.fired_slot = out_slot_q;
  assign res_o.fired      = out_fired_q;
  assign res_o.last       = out_last_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("output register loaded while a result is still held");

  a_cmd_step_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.apply_cmd && (ctl_i.step || ctl_i.finish || ctl_i.clr_idx)))
    else $error("command write overlaps the sweep");

  a_finish_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.finish |=> !has_pend_q && out_valid_q && out_last_q)
    else $error("sweep end did not emit a final result");

endmodule

`default_nettype wire

// File: hdl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler: a bank of NUM_TASKS periodic timer slots.
// A slot command gives one result; the next command may follow at once when the output is free.
// A tick passes through acceptance, a sweep of one slot per cycle (paused by output stalls) through
// the shared increment-and-compare unit, and a closing state that emits the final result.
// Reset clears all periods, counts and active flags at once.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_tick_scheduler (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ptts_cmd_if.sink   cmd_i,
  ptts_res_if.source res_o
);
  import ptts_pkg::*;

  ptts_ctl_t  ctl;
  ptts_stat_t stat;

  ptts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  ptts_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .stat_o (stat),
    .cmd_i  (cmd_i),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
